@@ rtl/core/hkc_pkg.sv @@
// ----------------------------------------------------------------------------
// hkc_pkg
// Shared types for the Hermite keyframe curve core.
// ----------------------------------------------------------------------------
package hkc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KeyIdxW = 4;
  localparam int unsigned KeysCfgW = 5;
  localparam int unsigned KeyKeysReset = 2;

  localparam logic ActWrite = 1'b0;
  localparam logic ActEval = 1'b1;

  localparam logic StatusDone = 1'b0;
  localparam logic StatusRange = 1'b1;

  // one table entry as stored in the key memory
  typedef struct packed {
    logic [DataW-1:0]        time_q;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] tin;
    logic signed [DataW-1:0] tout;
  } hkc_key_t;

  localparam int unsigned KeyW = $bits(hkc_key_t);

  // request into the blend unit
  typedef struct packed {
    logic                    start;
    logic [DataW-1:0]        span;
    logic [DataW-1:0]        diff;
    logic signed [DataW-1:0] v0;
    logic signed [DataW-1:0] tout0;
    logic signed [DataW-1:0] v1;
    logic signed [DataW-1:0] tin1;
  } hkc_math_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] value;
  } hkc_math_rsp_t;

endpackage

@@ rtl/core/hkc_ram.sv @@
// ----------------------------------------------------------------------------
// hkc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hkc_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/hkc_math.sv @@
// ----------------------------------------------------------------------------
// hkc_math
// Hermite blend unit: serial fraction divide, shared multiplier for powers
// and tangent scaling, then a four-term multiply-accumulate.
// ----------------------------------------------------------------------------
module hkc_math (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hkc_pkg::hkc_math_req_t req,
  output hkc_pkg::hkc_math_rsp_t rsp
);
  import hkc_pkg::*;

  typedef enum logic [8:0] {
    MS_IDLE  = 9'b000000001,
    MS_DIV   = 9'b000000010,
    MS_U2    = 9'b000000100,
    MS_U3    = 9'b000001000,
    MS_M0    = 9'b000010000,
    MS_M1    = 9'b000100000,
    MS_BASIS = 9'b001000000,
    MS_ACC   = 9'b010000000,
    MS_DONE  = 9'b100000000
  } ms_state_t;

  ms_state_t state_r, state_nxt;

  logic [DataW-1:0]        span_r, u_r, u2_r, u3_r;
  logic [DataW:0]          rem_r;
  logic [5:0]              cnt_r;
  logic signed [DataW-1:0] v0_r, tout0_r, v1_r, tin1_r;
  logic signed [48:0]      m0_r, m1_r;
  logic signed [19:0]      h_r [4];
  logic signed [68:0]      prod_r;
  logic signed [71:0]      acc_r;
  logic [2:0]              j_r;

  // restoring divide step
  logic [DataW:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_r[DataW-1:0], 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, span_r});

  // shared 33x33 multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    ma = {1'b0, u_r};
    mb = {1'b0, u_r};
    case (state_r)
      MS_U3: begin
        ma = {1'b0, u2_r};
      end
      MS_M0: begin
        ma = {tout0_r[DataW-1], tout0_r};
        mb = {1'b0, span_r};
      end
      MS_M1: begin
        ma = {tin1_r[DataW-1], tin1_r};
        mb = {1'b0, span_r};
      end
      default: begin
      end
    endcase
  end
  assign mp = ma * mb;

  // basis values, Q.32 then floored to Q.16
  logic signed [35:0] su, su2, su3, b00, b10, b01, b11;
  assign su  = {4'b0, u_r};
  assign su2 = {4'b0, u2_r};
  assign su3 = {4'b0, u3_r};
  assign b00 = (su3 <<< 1) - (su2 + (su2 <<< 1)) + 36'sh1_0000_0000;
  assign b10 = su3 - (su2 <<< 1) + su;
  assign b01 = su3 - su2;
  assign b11 = (su2 + (su2 <<< 1)) - (su3 <<< 1);

  // accumulate operand select
  logic signed [48:0] xsel;
  always_comb begin
    case (j_r[1:0])
      2'd0:    xsel = 49'(v0_r);
      2'd1:    xsel = m0_r;
      2'd2:    xsel = m1_r;
      default: xsel = 49'(v1_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_IDLE:  if (req.start) state_nxt = MS_DIV;
      MS_DIV:   if (cnt_r == 6'd31) state_nxt = MS_U2;
      MS_U2:    state_nxt = MS_U3;
      MS_U3:    state_nxt = MS_M0;
      MS_M0:    state_nxt = MS_M1;
      MS_M1:    state_nxt = MS_BASIS;
      MS_BASIS: state_nxt = MS_ACC;
      MS_ACC:   if (j_r == 3'd4) state_nxt = MS_DONE;
      MS_DONE:  state_nxt = MS_IDLE;
      default:  state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MS_IDLE: begin
        if (req.start) begin
          span_r  <= req.span;
          rem_r   <= {1'b0, req.diff};
          u_r     <= '0;
          cnt_r   <= '0;
          v0_r    <= req.v0;
          tout0_r <= req.tout0;
          v1_r    <= req.v1;
          tin1_r  <= req.tin1;
        end
      end
      MS_DIV: begin
        rem_r <= q_bit ? (rem_sh - {1'b0, span_r}) : rem_sh;
        u_r   <= {u_r[DataW-2:0], q_bit};
        cnt_r <= cnt_r + 6'd1;
      end
      MS_U2: u2_r <= mp[63:32];
      MS_U3: u3_r <= mp[63:32];
      MS_M0: m0_r <= mp[64:16];
      MS_M1: m1_r <= mp[64:16];
      MS_BASIS: begin
        h_r[0] <= b00[35:16];
        h_r[1] <= b10[35:16];
        h_r[2] <= b01[35:16];
        h_r[3] <= b11[35:16];
        acc_r  <= '0;
        j_r    <= '0;
      end
      MS_ACC: begin
        prod_r <= h_r[j_r[1:0]] * xsel;
        if (j_r != 3'd0) begin
          acc_r <= acc_r + 72'(prod_r);
        end
        j_r <= j_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  // floor by 2^16 and saturate
  logic signed [55:0] res_s;
  assign res_s = acc_r[71:16];

  always_comb begin
    rsp.done = (state_r == MS_DONE);
    if (res_s > 56'sd2147483647) begin
      rsp.value = 32'sh7FFF_FFFF;
    end else if (res_s < -56'sd2147483648) begin
      rsp.value = 32'sh8000_0000;
    end else begin
      rsp.value = res_s[31:0];
    end
  end

endmodule

@@ rtl/core/hermite_keyframe_curve_core.sv @@
// Flow: a write request goes from idle to the put state; an evaluate request reads
//   and checks each key scanned, plus a blend when needed (32-step serial divide,
//   shared multiplier, four-term MAC).
// Throughput: one request at a time; a new request is taken while the result waits.
// Reset: synchronous active-low; keys_in_use resets to 2, key memory is not cleared.
// ----------------------------------------------------------------------------
// hermite_keyframe_curve_core
// Keyframe table in RAM with a sequential search and a cubic Hermite blend.
// ----------------------------------------------------------------------------
module hermite_keyframe_curve_core #(
  parameter int unsigned KEY_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hkc_pkg::KeysCfgW-1:0]        cfg_keys_in_use,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [hkc_pkg::KeyIdxW-1:0]         in_key_index,
  input  logic [hkc_pkg::DataW-1:0]           in_key_time,
  input  logic signed [hkc_pkg::DataW-1:0]    in_key_value,
  input  logic signed [hkc_pkg::DataW-1:0]    in_in_tangent,
  input  logic signed [hkc_pkg::DataW-1:0]    in_out_tangent,
  input  logic [hkc_pkg::DataW-1:0]           in_query_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hkc_pkg::DataW-1:0]    out_curve_value,
  output logic                                out_status
);
  import hkc_pkg::*;

  localparam int unsigned AW = $clog2(KEY_DEPTH);
  localparam int unsigned CW = $clog2(KEY_DEPTH + 1);
  localparam int unsigned NW = (CW > KeysCfgW) ? CW : KeysCfgW;
  localparam logic [NW-1:0] DepthN = NW'(KEY_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_MATH = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [KeysCfgW-1:0]     keys_r;
  logic [DataW-1:0]        q_r, t0_r;
  logic signed [DataW-1:0] v0_r, tout0_r;
  logic [NW-1:0]           i_r;
  logic                    have0_r;
  logic signed [DataW-1:0] res_val_r;
  logic                    res_status_r;
  logic                    out_valid_r;
  logic signed [DataW-1:0] out_val_r;
  logic                    out_status_r;

  logic          in_acc, wr_en, rd_en;
  logic [NW-1:0] n_keys;
  logic [KeyW-1:0] rd_data;
  hkc_key_t      key_rd, key_wr;
  hkc_math_req_t math_req;
  hkc_math_rsp_t math_rsp;
  logic          hit_lo, hit_hi;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign n_keys = (NW'(keys_r) < DepthN) ? NW'(keys_r) : DepthN;

  assign key_wr = '{time_q: in_key_time, value: in_key_value,
                    tin: in_in_tangent, tout: in_out_tangent};
  assign wr_en  = in_acc && (in_action == ActWrite) &&
                  ({{NW{1'b0}}, in_key_index} < {{KeyIdxW{1'b0}}, DepthN});
  assign rd_en  = (state_r == S_RD) && (i_r < n_keys);

  hkc_ram #(.WIDTH(KeyW), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_key_index)),
    .wr_data (key_wr),
    .rd_en   (rd_en),
    .rd_addr (i_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign key_rd = hkc_key_t'(rd_data);
  assign hit_lo = (key_rd.time_q <= q_r);
  assign hit_hi = (key_rd.time_q >= q_r);

  always_comb begin
    math_req       = '0;
    math_req.start = (state_r == S_CHK) && hit_hi && !hit_lo && have0_r;
    math_req.span  = key_rd.time_q - t0_r;
    math_req.diff  = q_r - t0_r;
    math_req.v0    = v0_r;
    math_req.tout0 = tout0_r;
    math_req.v1    = key_rd.value;
    math_req.tin1  = key_rd.tin;
  end

  hkc_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (math_req),
    .rsp   (math_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = (in_action == ActEval) ? S_RD : S_PUT;
      S_RD:   state_nxt = rd_en ? S_CHK : S_PUT;
      S_CHK: begin
        if (!hit_hi) state_nxt = S_RD;
        else if (hit_lo || !have0_r) state_nxt = S_PUT;
        else state_nxt = S_MATH;
      end
      S_MATH: if (math_rsp.done) state_nxt = S_PUT;
      S_PUT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      keys_r      <= KeysCfgW'(KeyKeysReset);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        keys_r <= cfg_keys_in_use;
      end
      if (state_r == S_PUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r          <= in_query_time;
        i_r          <= '0;
        have0_r      <= 1'b0;
        res_val_r    <= '0;
        res_status_r <= StatusDone;
      end
      S_RD: begin
        // ran off the end of the keys in use
        if (!rd_en) begin
          res_status_r <= StatusRange;
        end
      end
      S_CHK: begin
        if (hit_lo) begin
          have0_r <= 1'b1;
          t0_r    <= key_rd.time_q;
          v0_r    <= key_rd.value;
          tout0_r <= key_rd.tout;
        end
        i_r <= i_r + NW'(1);
        if (hit_hi) begin
          if (hit_lo) begin
            res_val_r <= key_rd.value;
          end else if (!have0_r) begin
            res_status_r <= StatusRange;
          end
        end
      end
      S_MATH: if (math_rsp.done) res_val_r <= math_rsp.value;
      default: begin
      end
    endcase
    if (state_r == S_PUT && (!out_valid_r || out_ready)) begin
      out_val_r    <= res_val_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_val_r;
  assign out_status      = out_status_r;

  // checks
  a_math_start_in_chk: assert property (@(posedge clk) disable iff (!rst_n)
    math_req.start |=> state_r == S_MATH)
    else $error("blend started outside of search hit");

  a_math_done_in_math: assert property (@(posedge clk) disable iff (!rst_n)
    math_rsp.done |-> state_r == S_MATH)
    else $error("blend result with no request waiting");

  a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> state_r == S_CHK)
    else $error("key read not followed by check");

  a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT))
    else $error("result loaded outside of put state");

endmodule
